/* sv/awglt_pkg.sv */
// shared types and constants of the word grid lock tracker
`timescale 1ns / 1ps
`default_nettype none

package awglt_pkg;

   // command codes
   localparam logic CMD_WORD = 1'b0;
   localparam logic CMD_GAP  = 1'b1;

   // preamble type codes in word bits 23..21
   localparam logic [2:0] PTYPE_TO   = 3'd2;
   localparam logic [2:0] PTYPE_TWAS = 3'd3;
   localparam logic [2:0] PTYPE_FROM = 3'd4;
   localparam logic [2:0] PTYPE_TIS  = 3'd5;

   // one input beat
   typedef struct packed {
      logic        command;
      logic [31:0] sample_position;
      logic        decode_pass;
      logic        fec_clean;
      logic        undecodable;
      logic [5:0]  vote_count;
      logic [23:0] word_bits;
      logic [15:0] energy;
   } req_item_type;

   // one result beat
   typedef struct packed {
      logic [23:0] out_word;
      logic        out_decoded;
      logic [5:0]  out_votes;
      logic [31:0] out_position;
      logic        last;
   } rsp_item_type;

   // results of one item handed to the result queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type first;
      rsp_item_type second;
   } result_pair_type;

endpackage

`default_nettype wire

/* sv/awglt_req_if.sv */
// input channel of word candidates and silence gap events
`timescale 1ns / 1ps
`default_nettype none

interface awglt_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [31:0] sample_position;
   logic        decode_pass;
   logic        fec_clean;
   logic        undecodable;
   logic [5:0]  vote_count;
   logic [23:0] word_bits;
   logic [15:0] energy;

   modport source (
      output valid, command, sample_position, decode_pass, fec_clean,
             undecodable, vote_count, word_bits, energy,
      input  ready
   );
   modport sink (
      input  valid, command, sample_position, decode_pass, fec_clean,
             undecodable, vote_count, word_bits, energy,
      output ready
   );
endinterface

`default_nettype wire

/* sv/awglt_rsp_if.sv */
// result channel of emitted words
`timescale 1ns / 1ps
`default_nettype none

interface awglt_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] out_word;
   logic        out_decoded;
   logic [5:0]  out_votes;
   logic [31:0] out_position;
   logic        last;

   modport source (
      output valid, out_word, out_decoded, out_votes, out_position, last,
      input  ready
   );
   modport sink (
      input  valid, out_word, out_decoded, out_votes, out_position, last,
      output ready
   );
endinterface

`default_nettype wire

/* sv/awglt_csr_if.sv */
// configuration write channel for the vote threshold
`timescale 1ns / 1ps
`default_nettype none

interface awglt_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

/* sv/awglt_phase.sv */
// input pipeline that reduces the sample position modulo the word length
`timescale 1ns / 1ps
`default_nettype none

module awglt_phase #(
   parameter int WORD_LEN_SAMPLES = 3136
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire awglt_pkg::req_item_type in_item,
   output logic                        out_valid,
   output awglt_pkg::req_item_type     out_item,
   output logic [$clog2(WORD_LEN_SAMPLES)-1:0] out_pos_mod
);
   import awglt_pkg::*;

   localparam int PW = $clog2(WORD_LEN_SAMPLES);
   localparam longint unsigned TWO32 = 64'h1_0000_0000;
   localparam longint unsigned RECIP = TWO32 / WORD_LEN_SAMPLES;
   localparam int RW = $clog2(RECIP + 1);
   localparam logic [RW-1:0] RECIP_W = RW'(RECIP);
   localparam logic [31:0] WL32 = 32'(WORD_LEN_SAMPLES);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   req_item_type item1_ff, item2_ff, item3_ff, item4_ff;
   logic [32+RW-1:0] prod2_ff, prod2_in;
   logic [31:0] qw3_ff, qw3_in;
   logic [PW-1:0] mod4_ff, mod4_in;
   logic [RW-1:0] quot;
   logic [31:0] rem_raw;

   // estimated quotient from the reciprocal, off by at most one
   assign prod2_in = item1_ff.sample_position * RECIP_W;
   assign quot     = prod2_ff[32+RW-1:32];
   assign qw3_in   = 32'(quot) * WL32;

   // one correction step brings the remainder below the word length
   assign rem_raw = item3_ff.sample_position - qw3_ff;
   assign mod4_in = (rem_raw >= WL32) ? PW'(rem_raw - WL32) : PW'(rem_raw);

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (advance) begin
         item1_ff <= in_item;
         item2_ff <= item1_ff;
         prod2_ff <= prod2_in;
         item3_ff <= item2_ff;
         qw3_ff   <= qw3_in;
         item4_ff <= item3_ff;
         mod4_ff  <= mod4_in;
      end
   end

   assign out_valid   = v4_ff;
   assign out_item    = item4_ff;
   assign out_pos_mod = mod4_ff;

endmodule

`default_nettype wire

/* sv/awglt_core.sv */
// grid lock state, candidate gate, refinement window and result forming
`timescale 1ns / 1ps
`default_nettype none

module awglt_core #(
   parameter int SYMBOL_SAMPLES   = 64,
   parameter int WORD_LEN_SAMPLES = 3136,
   parameter int LOCK_TIMEOUT     = 12544
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    fire,
   input  wire awglt_pkg::req_item_type item,
   input  wire logic [$clog2(WORD_LEN_SAMPLES)-1:0] pos_mod,
   input  wire logic [5:0]              min_votes,
   output awglt_pkg::result_pair_type   res
);
   import awglt_pkg::*;

   localparam int PW = $clog2(WORD_LEN_SAMPLES);
   localparam longint unsigned TWO32 = 64'h1_0000_0000;
   localparam logic [31:0] SYM32 = 32'(SYMBOL_SAMPLES);
   localparam logic [31:0] TO32  = 32'(LOCK_TIMEOUT);
   localparam logic [31:0] M32   = 32'(WORD_LEN_SAMPLES - SYMBOL_SAMPLES);
   localparam logic [PW:0] WL_P1 = (PW+1)'(WORD_LEN_SAMPLES);
   localparam logic [PW-1:0] WRAP_C = PW'(TWO32 % WORD_LEN_SAMPLES);

   logic          locked_ff, locked_in;
   logic [31:0]   anchor_ff, anchor_in;
   logic [PW-1:0] anc_mod_ff, anc_mod_in;
   logic [31:0]   unc_ff, unc_in;
   logic          refining_ff, refining_in;
   logic [31:0]   start_ff, start_in;
   logic [15:0]   best_energy_ff, best_energy_in;
   logic [31:0]   best_pos_ff, best_pos_in;
   logic [PW-1:0] best_mod_ff, best_mod_in;
   logic [5:0]    best_votes_ff, best_votes_in;
   logic [23:0]   best_word_ff, best_word_in;

   logic          cmd_gap, win_close, lock1, ref1, timed_out, lock2;
   logic [31:0]   pos, anchor1, grid_span;
   logic [PW-1:0] anc_mod1, ph;
   logic [PW:0]   t1, t1b, t2;
   logic [31:0]   ph32;
   logic [2:0]    ptype;
   logic          votes_ok, preamble_ok, spacing_ok, phase_ok, gate_ok;
   logic          take, first, better, report, commit, rep_now;
   rsp_item_type  commit_item, report_item;

   assign pos     = item.sample_position;
   assign cmd_gap = (item.command == CMD_GAP);

   // window close and lock timeout ahead of the gate
   assign win_close = refining_ff && ((pos - start_ff) >= SYM32);
   assign lock1     = locked_ff || win_close;
   assign ref1      = refining_ff && !win_close;
   assign anchor1   = win_close ? best_pos_ff : anchor_ff;
   assign anc_mod1  = win_close ? best_mod_ff : anc_mod_ff;
   assign grid_span = pos - anchor1;
   assign timed_out = lock1 && !ref1 && (grid_span > TO32);
   assign lock2     = lock1 && !timed_out;

   // grid phase from the residues, corrected for wrap of the difference
   assign t1   = {1'b0, pos_mod} + (WL_P1 - {1'b0, anc_mod1});
   assign t1b  = (t1 >= WL_P1) ? t1 - WL_P1 : t1;
   assign t2   = t1b + ((pos < anchor1) ? {1'b0, WRAP_C} : '0);
   assign ph   = (t2 >= WL_P1) ? PW'(t2 - WL_P1) : PW'(t2);
   assign ph32 = 32'(ph);

   // candidate gate
   assign ptype       = item.word_bits[23:21];
   assign votes_ok    = (item.vote_count >= min_votes);
   assign preamble_ok = (ptype == PTYPE_TO) || (ptype == PTYPE_TWAS)
                        || (ptype == PTYPE_FROM) || (ptype == PTYPE_TIS);
   assign spacing_ok  = (grid_span >= M32);
   assign phase_ok    = (ph32 <= SYM32) || (ph32 >= M32);
   assign gate_ok     = votes_ok && (lock2 ? (spacing_ok && (item.fec_clean || phase_ok))
                                           : preamble_ok);

   assign take   = item.decode_pass && gate_ok;
   assign first  = !ref1;
   assign better = first || (item.energy > best_energy_ff);

   // exact-phase uncorrectable report
   assign report = !item.decode_pass && !ref1 && lock2 && votes_ok && item.undecodable
                   && spacing_ok && (ph == '0) && ((pos - unc_ff) >= M32);

   assign commit  = cmd_gap ? refining_ff : win_close;
   assign rep_now = !cmd_gap && report;

   // next state
   always_comb begin
      locked_in      = locked_ff;
      anchor_in      = anchor_ff;
      anc_mod_in     = anc_mod_ff;
      unc_in         = unc_ff;
      refining_in    = refining_ff;
      start_in       = start_ff;
      best_energy_in = best_energy_ff;
      best_pos_in    = best_pos_ff;
      best_mod_in    = best_mod_ff;
      best_votes_in  = best_votes_ff;
      best_word_in   = best_word_ff;
      if (fire) begin
         if (cmd_gap) begin
            locked_in   = 1'b0;
            refining_in = 1'b0;
            if (refining_ff) begin
               anchor_in  = best_pos_ff;
               anc_mod_in = best_mod_ff;
            end
         end else begin
            locked_in   = lock2;
            anchor_in   = anchor1;
            anc_mod_in  = anc_mod1;
            refining_in = ref1 || take;
            if (take && first) begin
               start_in = pos;
            end
            if (take && better) begin
               best_energy_in = item.energy;
               best_pos_in    = pos;
               best_mod_in    = pos_mod;
               best_votes_in  = item.vote_count;
               best_word_in   = item.word_bits;
            end
            if (report) begin
               unc_in = pos;
            end
         end
      end
   end

   // result forming
   always_comb begin
      commit_item.out_word     = best_word_ff;
      commit_item.out_decoded  = 1'b1;
      commit_item.out_votes    = best_votes_ff;
      commit_item.out_position = best_pos_ff;
      commit_item.last         = !rep_now;
      report_item.out_word     = item.word_bits;
      report_item.out_decoded  = 1'b0;
      report_item.out_votes    = '0;
      report_item.out_position = pos;
      report_item.last         = 1'b1;
      res = '0;
      if (fire) begin
         priority if (commit && rep_now) begin
            res.count  = 2'd2;
            res.first  = commit_item;
            res.second = report_item;
         end else if (commit) begin
            res.count = 2'd1;
            res.first = commit_item;
         end else if (rep_now) begin
            res.count = 2'd1;
            res.first = report_item;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff      <= 1'b0;
         anchor_ff      <= '0;
         anc_mod_ff     <= '0;
         unc_ff         <= '0;
         refining_ff    <= 1'b0;
         start_ff       <= '0;
         best_energy_ff <= '0;
         best_pos_ff    <= '0;
         best_mod_ff    <= '0;
         best_votes_ff  <= '0;
         best_word_ff   <= '0;
      end else begin
         locked_ff      <= locked_in;
         anchor_ff      <= anchor_in;
         anc_mod_ff     <= anc_mod_in;
         unc_ff         <= unc_in;
         refining_ff    <= refining_in;
         start_ff       <= start_in;
         best_energy_ff <= best_energy_in;
         best_pos_ff    <= best_pos_in;
         best_mod_ff    <= best_mod_in;
         best_votes_ff  <= best_votes_in;
         best_word_ff   <= best_word_in;
      end
   end

endmodule

`default_nettype wire

/* sv/awglt_rsp_fifo.sv */
// four-beat result queue taking up to two beats per cycle
`timescale 1ns / 1ps
`default_nettype none

module awglt_rsp_fifo (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire awglt_pkg::result_pair_type push,
   input  wire logic                       pop,
   output awglt_pkg::rsp_item_type         head,
   output logic                            not_empty,
   output logic                            room
);
   import awglt_pkg::*;

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   rsp_item_type entry_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in, wr_next;
   logic [CW-1:0] count_ff, count_in;

   assign wr_next   = wr_ptr_ff + AW'(1);
   assign wr_ptr_in = wr_ptr_ff + AW'(push.count);
   assign rd_ptr_in = rd_ptr_ff + AW'(pop);
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   // room for a full pair of beats, from the registered fill only
   assign room      = (count_ff <= CW'(DEPTH - 2));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // pointers and fill
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_next] <= push.second;
      end
   end

endmodule

`default_nettype wire

/* sv/ale_word_grid_lock_tracker.sv */
// top level of the word grid lock tracker
`timescale 1ns / 1ps
`default_nettype none

// Takes one word candidate or silence gap beat per clock. The sample position
// is reduced modulo the word length in a four-stage input pipeline (reciprocal
// multiply, quotient back-multiply, one correction step) feeding the lock,
// gate and refinement logic, which works on one item per cycle while the
// four-beat output queue has room for a pair of results. An item that both
// closes a refinement window and lands as an on-grid uncorrectable word gives
// two result beats. Intake holds while the queue has fewer than two free
// entries and the last stage holds an item, so sustained rate is one item per
// cycle as long as the results drain at the rate they are made. The vote
// threshold register is written through the always-ready csr channel.
module ale_word_grid_lock_tracker #(
   parameter int SYMBOL_SAMPLES   = 64,
   parameter int WORD_LEN_SAMPLES = 3136,
   parameter int LOCK_TIMEOUT     = 12544
) (
   input  wire logic   clock,
   input  wire logic   reset,
   awglt_req_if.sink   req_bus,
   awglt_rsp_if.source rsp_bus,
   awglt_csr_if.sink   csr_bus
);
   import awglt_pkg::*;

   localparam int PW = $clog2(WORD_LEN_SAMPLES);

   logic            advance, stage_valid, core_fire, fifo_room, fifo_ne, rsp_pop;
   logic [5:0]      min_votes_ff;
   req_item_type    in_item, stage_item;
   logic [PW-1:0]   stage_mod;
   result_pair_type core_res;
   rsp_item_type    head;

   // vote threshold register
   assign csr_bus.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_votes_ff <= '0;
      end else if (csr_bus.valid) begin
         min_votes_ff <= csr_bus.data;
      end
   end

   // input beat
   assign in_item.command         = req_bus.command;
   assign in_item.sample_position = req_bus.sample_position;
   assign in_item.decode_pass     = req_bus.decode_pass;
   assign in_item.fec_clean       = req_bus.fec_clean;
   assign in_item.undecodable     = req_bus.undecodable;
   assign in_item.vote_count      = req_bus.vote_count;
   assign in_item.word_bits       = req_bus.word_bits;
   assign in_item.energy          = req_bus.energy;

   // pipeline holds only when the last stage has nowhere to put its results
   assign advance       = !(stage_valid && !fifo_room);
   assign core_fire     = stage_valid && fifo_room;
   assign req_bus.ready = advance;

   awglt_phase #(
      .WORD_LEN_SAMPLES(WORD_LEN_SAMPLES)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_bus.valid),
      .in_item    (in_item),
      .out_valid  (stage_valid),
      .out_item   (stage_item),
      .out_pos_mod(stage_mod)
   );

   awglt_core #(
      .SYMBOL_SAMPLES  (SYMBOL_SAMPLES),
      .WORD_LEN_SAMPLES(WORD_LEN_SAMPLES),
      .LOCK_TIMEOUT    (LOCK_TIMEOUT)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .fire     (core_fire),
      .item     (stage_item),
      .pos_mod  (stage_mod),
      .min_votes(min_votes_ff),
      .res      (core_res)
   );

   assign rsp_pop = rsp_bus.valid && rsp_bus.ready;

   awglt_rsp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (core_res),
      .pop      (rsp_pop),
      .head     (head),
      .not_empty(fifo_ne),
      .room     (fifo_room)
   );

   // result beat
   assign rsp_bus.valid        = fifo_ne;
   assign rsp_bus.out_word     = head.out_word;
   assign rsp_bus.out_decoded  = head.out_decoded;
   assign rsp_bus.out_votes    = head.out_votes;
   assign rsp_bus.out_position = head.out_position;
   assign rsp_bus.last         = head.last;

   // results are only made when the queue can hold a full pair
   a_push_room : assert property (@(posedge clock) disable iff (reset)
      (core_res.count != 2'd0) |-> fifo_room)
      else $error("results pushed without queue room");

   // a pair is a commit followed by the report, last on the second only
   a_pair_order : assert property (@(posedge clock) disable iff (reset)
      (core_res.count == 2'd2) |->
         (core_res.first.out_decoded && !core_res.first.last
          && !core_res.second.out_decoded && core_res.second.last))
      else $error("malformed result pair");

   // an uncorrectable report carries no votes
   a_report_votes : assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.out_decoded) |-> (rsp_bus.out_votes == 6'd0))
      else $error("uncorrectable report with votes");

endmodule

`default_nettype wire

/* test/ale_word_grid_lock_tracker_test.sv */
// testbench of the word grid lock tracker: directed and random beats checked against a predictor
`timescale 1ns / 1ps

module ale_word_grid_lock_tracker_test;
   import awglt_pkg::*;

   localparam int unsigned SYM_LEN      = 64;
   localparam int unsigned WORD_LEN     = 3136;
   localparam int unsigned LOCK_LIMIT   = 12544;
   localparam int unsigned GRID_MARGIN  = WORD_LEN - SYM_LEN;
   localparam int unsigned DRAIN_CYCLES = 16;
   localparam int unsigned RANDOM_BEATS = 1300;
   localparam int unsigned VOTES_MAX    = 49;

   logic clock;
   logic reset;

   awglt_req_if req_bus ();
   awglt_rsp_if rsp_bus ();
   awglt_csr_if csr_bus ();

   ale_word_grid_lock_tracker #(
      .SYMBOL_SAMPLES   (SYM_LEN),
      .WORD_LEN_SAMPLES (WORD_LEN),
      .LOCK_TIMEOUT     (LOCK_LIMIT)
   ) i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // predicted tracker state
   logic [5:0]  vote_floor;
   logic        locked;
   logic [31:0] anchor;
   logic [31:0] bad_anchor;
   logic        in_window;
   logic [31:0] window_start;
   logic [15:0] top_energy;
   logic [31:0] top_pos;
   logic [5:0]  top_votes;
   logic [23:0] top_word;

   rsp_item_type expected_words[$];
   int unsigned  mismatch_count;

   // idling control
   bit          in_steady;
   bit          out_steady;
   int unsigned rsp_gap;
   int unsigned rsp_hold;

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // commit the kept word of the refinement window
   function automatic rsp_item_type commit_window();
      rsp_item_type res;
      locked    = 1'b1;
      anchor    = top_pos;
      in_window = 1'b0;
      res.out_word     = top_word;
      res.out_decoded  = 1'b1;
      res.out_votes    = top_votes;
      res.out_position = top_pos;
      res.last         = 1'b0;
      return res;
   endfunction

   // work out the result beats of one accepted beat
   task automatic predict_beat(input req_item_type beat);
      rsp_item_type outs[$];
      rsp_item_type res;
      logic [31:0]  pos;
      logic [31:0]  span;
      logic [31:0]  phase;
      logic         pass;
      pos = beat.sample_position;
      if (beat.command == CMD_GAP) begin
         if (in_window)
            outs.push_back(commit_window());
         locked = 1'b0;
      end else begin
         if (in_window && (pos - window_start) >= SYM_LEN)
            outs.push_back(commit_window());
         if (locked && !in_window && (pos - anchor) > LOCK_LIMIT)
            locked = 1'b0;
         span  = pos - anchor;
         phase = span % WORD_LEN;
         if (beat.decode_pass) begin
            // vote, preamble and grid gate
            pass = (beat.vote_count >= vote_floor);
            if (pass && !locked)
               pass = (beat.word_bits[23:21] >= PTYPE_TO)
                      && (beat.word_bits[23:21] <= PTYPE_TIS);
            else if (pass) begin
               if (span < GRID_MARGIN)
                  pass = 1'b0;
               else if (!beat.fec_clean)
                  pass = (phase <= SYM_LEN) || (phase >= GRID_MARGIN);
            end
            if (pass) begin
               if (!in_window || beat.energy > top_energy) begin
                  top_energy = beat.energy;
                  top_pos    = pos;
                  top_votes  = beat.vote_count;
                  top_word   = beat.word_bits;
               end
               if (!in_window) begin
                  in_window    = 1'b1;
                  window_start = pos;
               end
            end
         end else if (!in_window && locked && beat.vote_count >= vote_floor
                      && beat.undecodable) begin
            // on-grid uncorrectable report
            if (span >= GRID_MARGIN && phase == 0 && (pos - bad_anchor) >= GRID_MARGIN) begin
               bad_anchor       = pos;
               res.out_word     = beat.word_bits;
               res.out_decoded  = 1'b0;
               res.out_votes    = '0;
               res.out_position = pos;
               res.last         = 1'b0;
               outs.push_back(res);
            end
         end
      end
      if (outs.size() > 0)
         outs[outs.size() - 1].last = 1'b1;
      foreach (outs[i])
         expected_words.push_back(outs[i]);
   endtask

   // send one beat after a random gap, predict on acceptance
   task automatic send_beat(input req_item_type beat);
      int unsigned gap;
      gap = in_steady ? 0 : $urandom_range(0, 7);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.command         <= beat.command;
      req_bus.sample_position <= beat.sample_position;
      req_bus.decode_pass     <= beat.decode_pass;
      req_bus.fec_clean       <= beat.fec_clean;
      req_bus.undecodable     <= beat.undecodable;
      req_bus.vote_count      <= beat.vote_count;
      req_bus.word_bits       <= beat.word_bits;
      req_bus.energy          <= beat.energy;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      predict_beat(beat);
   endtask

   task automatic release_input();
      @(negedge clock);
      req_bus.valid <= 1'b0;
   endtask

   // wait for all expected results, then let the pipeline settle
   task automatic wait_drained();
      release_input();
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [5:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      vote_floor = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   function automatic req_item_type word_beat(input logic [31:0] pos, input logic ok,
                                              input logic clean, input logic undec,
                                              input logic [5:0] votes,
                                              input logic [23:0] word,
                                              input logic [15:0] energy);
      req_item_type beat;
      beat.command         = CMD_WORD;
      beat.sample_position = pos;
      beat.decode_pass     = ok;
      beat.fec_clean       = clean;
      beat.undecodable     = undec;
      beat.vote_count      = votes;
      beat.word_bits       = word;
      beat.energy          = energy;
      return beat;
   endfunction

   // gap beat with junk in the ignored fields
   function automatic req_item_type gap_beat(input logic [31:0] pos);
      req_item_type beat;
      beat = word_beat(pos, 1'($urandom), 1'($urandom), 1'($urandom),
                       6'($urandom_range(0, VOTES_MAX)), 24'($urandom), 16'($urandom));
      beat.command = CMD_GAP;
      return beat;
   endfunction

   function automatic logic [23:0] preamble_word(input logic [2:0] ptype);
      return {ptype, 21'($urandom)};
   endfunction

   task automatic log_mismatch(input string what, input rsp_item_type want,
                               input rsp_item_type got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t %s: expected word %h dec %b votes %0d pos %h last %b",
                  $realtime, what, want.out_word, want.out_decoded, want.out_votes,
                  want.out_position, want.last);
         $display("%0t %s: got word %h dec %b votes %0d pos %h last %b",
                  $realtime, what, got.out_word, got.out_decoded,
                  got.out_votes, got.out_position, got.last);
      end
   endtask

   // check each result beat against the oldest expectation
   always @(posedge clock) begin : check_results
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         got.out_word     = rsp_bus.out_word;
         got.out_decoded  = rsp_bus.out_decoded;
         got.out_votes    = rsp_bus.out_votes;
         got.out_position = rsp_bus.out_position;
         got.last         = rsp_bus.last;
         rsp_gap = out_steady ? 0 : $urandom_range(0, 7);
         if (expected_words.size() == 0)
            log_mismatch("result beat with nothing expected", '0, got);
         else begin
            want = expected_words.pop_front();
            if (got.out_word !== want.out_word || got.out_decoded !== want.out_decoded
                || got.out_votes !== want.out_votes
                || got.out_position !== want.out_position || got.last !== want.last)
               log_mismatch("result beat differs", want, got);
         end
      end
   end

   // result side stalls and long hold-off
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else if (rsp_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // preamble types, energy ties and the window winner
   task automatic test_cold_lock();
      logic [31:0] base;
      base = 32'hFFFF_FF00;
      send_beat(gap_beat(base - 1));
      for (int t = 0; t < 8; t++)
         if (t < PTYPE_TO || t > PTYPE_TIS)
            send_beat(word_beat(base, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                                {3'(t), 21'h1F_FFFF}, 16'hFFFF));
      send_beat(word_beat(base, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX), {PTYPE_TO, 21'h0}, 16'd100));
      send_beat(word_beat(base + 10, 1'b1, 1'b0, 1'b0, 6'(VOTES_MAX),
                          {PTYPE_TIS, 21'h1F_FFFF}, 16'd100));
      send_beat(word_beat(base + 20, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                          preamble_word(PTYPE_TWAS), 16'hFFFF));
      send_beat(word_beat(base + SYM_LEN - 1, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                          preamble_word(PTYPE_FROM), 16'hFFFF));
      // window closes one symbol length after it opened
      send_beat(word_beat(base + SYM_LEN, 1'b0, 1'b0, 1'b0, 6'(VOTES_MAX),
                          24'($urandom), 16'h0));
      release_input();
   endtask

   // on-grid reports, phase gating and window commits
   task automatic test_grid_tracking();
      logic [31:0] a;
      logic [31:0] b;
      a = anchor;
      send_beat(word_beat(a + WORD_LEN, 1'b0, 1'b0, 1'b1, 6'(VOTES_MAX), 24'hFFFFFF, 16'h0));
      send_beat(word_beat(a + 2 * WORD_LEN, 1'b0, 1'b1, 1'b1, 6'(VOTES_MAX), 24'h0, 16'h0));
      send_beat(word_beat(a + 3 * WORD_LEN - 500, 1'b1, 1'b0, 1'b1, 6'(VOTES_MAX),
                          24'($urandom), 16'hFFFF));
      send_beat(word_beat(a + 3 * WORD_LEN - 1, 1'b0, 1'b0, 1'b1, 6'(VOTES_MAX),
                          24'($urandom), 16'h0));
      send_beat(word_beat(a + 3 * WORD_LEN - SYM_LEN, 1'b1, 1'b0, 1'b0, 6'(VOTES_MAX),
                          24'($urandom), 16'd5));
      send_beat(word_beat(a + 3 * WORD_LEN + SYM_LEN - 1, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                          24'($urandom), 16'd6));
      // on-grid report one word after the committed anchor
      b = top_pos;
      send_beat(word_beat(b + WORD_LEN, 1'b0, 1'b0, 1'b1, 6'(VOTES_MAX),
                          24'($urandom), 16'($urandom)));
      send_beat(word_beat(b + WORD_LEN + GRID_MARGIN - 1, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                          24'($urandom), 16'hFFFF));
      send_beat(word_beat(anchor + LOCK_LIMIT, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                          24'($urandom), 16'($urandom)));
      send_beat(gap_beat(anchor + LOCK_LIMIT + 1));
      release_input();
   endtask

   // lock holds at the timeout and drops one word later
   task automatic test_lock_timeout();
      logic [31:0] c;
      c = anchor + 10 * WORD_LEN;
      send_beat(word_beat(c, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX), preamble_word(PTYPE_TO), 16'h0));
      send_beat(word_beat(c + SYM_LEN, 1'b0, 1'b0, 1'b0, 6'(VOTES_MAX),
                          24'($urandom), 16'h0));
      send_beat(word_beat(c + LOCK_LIMIT, 1'b0, 1'b0, 1'b1, 6'(VOTES_MAX),
                          24'($urandom), 16'h0));
      send_beat(word_beat(c + LOCK_LIMIT + WORD_LEN, 1'b0, 1'b0, 1'b1, 6'(VOTES_MAX),
                          24'($urandom), 16'h0));
      release_input();
   endtask

   // vote threshold at the largest vote count used and at zero
   task automatic test_vote_threshold();
      logic [31:0] d;
      wait_drained();
      write_threshold(6'(VOTES_MAX));
      d = anchor + 20 * WORD_LEN;
      send_beat(gap_beat(d - 1));
      send_beat(word_beat(d, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX - 1),
                          preamble_word(PTYPE_TIS), 16'h0));
      send_beat(word_beat(d + 1, 1'b1, 1'b1, 1'b0, 6'(VOTES_MAX),
                          preamble_word(PTYPE_TIS), 16'h0));
      send_beat(gap_beat(d + 2));
      wait_drained();
      write_threshold(6'd0);
      send_beat(word_beat(d + 100, 1'b1, 1'b1, 1'b0, 6'd0, preamble_word(PTYPE_FROM), 16'h0));
      release_input();
   endtask

   // result side holds off while preamble and gap pairs keep coming
   task automatic test_backpressure();
      logic [31:0] p;
      @(posedge clock);
      rsp_hold  = 200;
      in_steady = 1'b1;
      p = anchor + 30 * WORD_LEN;
      for (int i = 0; i < 24; i++) begin
         send_beat(word_beat(p, 1'b1, 1'($urandom), 1'b0, 6'(VOTES_MAX),
                             preamble_word(3'($urandom_range(PTYPE_TO, PTYPE_TIS))),
                             16'($urandom)));
         send_beat(gap_beat(p + 1));
         p = p + 2;
      end
      in_steady = 1'b0;
      release_input();
   endtask

   // mostly well-formed traffic around the current grid, with noise
   task automatic test_random_traffic();
      req_item_type beat;
      logic [31:0]  cursor;
      logic [31:0]  pos;
      int unsigned  sent;
      int unsigned  pick;
      int unsigned  k;
      int           jitter;
      sent   = 0;
      cursor = $urandom;
      while (sent < RANDOM_BEATS) begin
         if (sent % 250 == 0) begin
            wait_drained();
            write_threshold(6'($urandom_range(0, 30)));
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
         end
         beat = word_beat(cursor, 1'b1, 1'($urandom), 1'($urandom),
                          ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, VOTES_MAX))
                                                      : 6'($urandom_range(vote_floor, VOTES_MAX)),
                          24'($urandom),
                          ($urandom_range(0, 7) == 0) ? top_energy : 16'($urandom));
         pick = $urandom_range(0, 99);
         if (pick < 20) begin
            // preamble near the current position
            pos = cursor + $urandom_range(0, 80);
            beat.word_bits[23:21] = 3'($urandom_range(PTYPE_TO, PTYPE_TIS));
         end else if (pick < 45) begin
            // candidate near a grid point
            k      = $urandom_range(1, 4);
            jitter = $urandom_range(0, 160);
            jitter = jitter - 80;
            pos    = anchor + k * WORD_LEN + jitter;
         end else if (pick < 60) begin
            // uncorrectable exactly on a grid point
            k = $urandom_range(1, 5);
            pos = anchor + k * WORD_LEN;
            beat.decode_pass = 1'b0;
            beat.undecodable = 1'b1;
         end else if (pick < 70) begin
            // another candidate inside the open window
            pos = in_window ? window_start + $urandom_range(0, SYM_LEN - 1) : cursor;
         end else if (pick < 78) begin
            pos  = cursor + $urandom_range(0, 3);
            beat = gap_beat(pos);
         end else begin
            pos = ($urandom_range(0, 5) == 0) ? 32'($urandom)
                                              : cursor + $urandom_range(0, 20000);
            beat.decode_pass = 1'($urandom);
         end
         beat.sample_position = pos;
         cursor = pos;
         send_beat(beat);
         sent++;
      end
      release_input();
   endtask

   initial begin
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.command         = CMD_WORD;
      req_bus.sample_position = '0;
      req_bus.decode_pass     = 1'b0;
      req_bus.fec_clean       = 1'b0;
      req_bus.undecodable     = 1'b0;
      req_bus.vote_count      = '0;
      req_bus.word_bits       = '0;
      req_bus.energy          = '0;
      csr_bus.valid           = 1'b0;
      csr_bus.data            = '0;
      vote_floor   = '0;
      locked       = 1'b0;
      anchor       = '0;
      bad_anchor   = '0;
      in_window    = 1'b0;
      window_start = '0;
      top_energy   = '0;
      top_pos      = '0;
      top_votes    = '0;
      top_word     = '0;
      mismatch_count = 0;
      in_steady  = 1'b0;
      out_steady = 1'b0;
      rsp_gap    = 0;
      rsp_hold   = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_threshold(6'd20);
      test_cold_lock();
      test_grid_tracking();
      test_lock_timeout();
      test_vote_threshold();
      test_backpressure();
      test_random_traffic();
      wait_drained();
      if (mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // run time limit
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

/* ale_word_grid_lock_tracker.f */
sv/awglt_pkg.sv
sv/awglt_req_if.sv
sv/awglt_rsp_if.sv
sv/awglt_csr_if.sv
sv/awglt_phase.sv
sv/awglt_core.sv
sv/awglt_rsp_fifo.sv
sv/ale_word_grid_lock_tracker.sv
test/ale_word_grid_lock_tracker_test.sv
